FILE: rtl/proportional_glyph_row_renderer_top_defines.svh
// ----------------------------------------------------------------------------
// Glyph row renderer assertion macros
// Clocked checks used by the renderer back part.
// ----------------------------------------------------------------------------
`ifndef PROPORTIONAL_GLYPH_ROW_RENDERER_TOP_DEFINES_SVH
`define PROPORTIONAL_GLYPH_ROW_RENDERER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PGR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never hold on a clock edge outside reset.
`define PGR_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`endif

FILE: rtl/pgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph row renderer package
// Shared types, constants and helpers.
// ----------------------------------------------------------------------------
package pgr_pkg;

  localparam int unsigned FontRowsDef      = 16;
  localparam int unsigned RowBytesDef      = 128;
  localparam int unsigned MaxGlyphWidthDef = 32;
  localparam int unsigned GlyphEntries     = 96;
  localparam int unsigned BitmapDepth      = 2048;
  localparam int unsigned ResultLimit      = 16;
  localparam int unsigned MaskW            = 32;

  localparam logic [1:0] KIND_LOAD_BITMAP = 2'd0;
  localparam logic [1:0] KIND_LOAD_GLYPH  = 2'd1;
  localparam logic [1:0] KIND_DRAW        = 2'd2;

  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_TILDE    = 8'h7e;
  localparam logic [7:0] CHAR_ASTERISK = 8'h2a;

  typedef struct packed {
    logic [1:0]         kind;
    logic [10:0]        table_index;
    logic [9:0]         table_value;
    logic [7:0]         char_code;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [23:0]        colour_rgb888;
    logic               first_of_string;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] row_x;
    logic signed [15:0] row_y;
    logic [9:0]         span_width;
    logic [31:0]        pixel_mask;
    logic [15:0]        colour_rgb565;
    logic               width_clipped;
    logic               last_row;
  } out_item_t;

  // Draw command from the front part to the back part.
  typedef struct packed {
    logic [9:0]  start;
    logic [9:0]  width;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] col;
  } draw_cmd_t;

  function automatic logic [15:0] to_rgb565(input logic [23:0] c);
    logic [23:0] r;
    r = ((c & 24'hf80000) >> 8) | ((c & 24'h00fc00) >> 5) | ((c & 24'h0000f8) >> 3);
    return r[15:0];
  endfunction

endpackage

FILE: rtl/proportional_glyph_row_renderer_top.sv
`timescale 1ns / 1ps
// A draw item passes the front part's START, END and OUT states and the back
// part's READ and PUSH states before its first row is queued. Each glyph row
// takes byte-serial bitmap reads and one queue write; the next item is taken
// only after the last row of a character, and a full result queue stalls rows.
// Reset: asynchronous, active low; clears the running advance and all control
// state. The glyph and bitmap tables are undefined until written.
// ----------------------------------------------------------------------------
// Proportional glyph row renderer
// Front part does table lookups, back part renders rows into a result queue.
// ----------------------------------------------------------------------------
module proportional_glyph_row_renderer_top #(
  parameter int unsigned FontRows      = pgr_pkg::FontRowsDef,
  parameter int unsigned RowBytes      = pgr_pkg::RowBytesDef,
  parameter int unsigned MaxGlyphWidth = pgr_pkg::MaxGlyphWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  pgr_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output pgr_pkg::out_item_t out_item_o
);
  import pgr_pkg::*;

  logic      cmd_valid, cmd_ready;
  draw_cmd_t cmd;
  logic      bm_we;

  // Bitmap byte loads go straight to the back part's RAM.
  assign bm_we = push && !full && in_item_i.kind == KIND_LOAD_BITMAP;

  // Hold the input while the back part renders, so no later load can change
  // the bitmap under a character that is still being read.
  pgr_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .hold_i(!cmd_ready), .in_i(in_item_i),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  pgr_back #(
    .FontRows(FontRows), .RowBytes(RowBytes), .MaxGlyphWidth(MaxGlyphWidth)
  ) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .bm_we_i(bm_we), .bm_waddr_i(in_item_i.table_index),
    .bm_wdata_i(in_item_i.table_value[7:0]),
    .empty_o(empty), .pop_i(pop), .out_o(out_item_o)
  );
endmodule

FILE: rtl/pgr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pgr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/pgr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph row renderer front part
// Accept items, run glyph table loads and lookups, build draw commands.
// ----------------------------------------------------------------------------
module pgr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic             hold_i,
  input  pgr_pkg::in_item_t in_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output pgr_pkg::draw_cmd_t cmd_o
);
  import pgr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]  state_q, state_d;
  in_item_t    item_q;
  logic [6:0]  code_q;
  logic [9:0]  start_q;
  logic [15:0] adv_q, adv_d;
  logic [15:0] base_adv_q;
  logic [9:0]  width_q;
  logic        gl_we;
  logic [6:0]  gl_raddr, gl_waddr;
  logic [9:0]  gl_rdata;
  logic [7:0]  code_map;
  logic        accept;

  // Hold every item while the front part is busy or the back part still reads the bitmap.
  assign full_o = (state_q != ST_IDLE) || hold_i;
  assign accept = push_i && !full_o;

  assign code_map = (in_i.char_code < CHAR_SPACE || in_i.char_code > CHAR_TILDE) ?
                    CHAR_ASTERISK : in_i.char_code;

  assign gl_we    = accept && in_i.kind == KIND_LOAD_GLYPH &&
                    in_i.table_index < 11'(GlyphEntries);
  assign gl_waddr = in_i.table_index[6:0];
  assign gl_raddr = (state_q == ST_IDLE) ? 7'(code_map - CHAR_SPACE) : 7'(code_q + 7'd1);

  pgr_ram #(.Width(10), .Depth(GlyphEntries)) u_glyph (
    .clk_i, .we_i(gl_we), .waddr_i(gl_waddr), .wdata_i(in_i.table_value),
    .raddr_i(gl_raddr), .rdata_o(gl_rdata)
  );

  always_comb begin
    state_d = state_q;
    adv_d   = adv_q;
    unique case (state_q)
      ST_IDLE:  if (accept && in_i.kind == KIND_DRAW) state_d = ST_START;
      ST_START: state_d = ST_END;
      ST_END: begin
        state_d = ST_OUT;
        // Last entry has no successor: treat it as zero.
        if (code_q != 7'(GlyphEntries - 1) && gl_rdata > start_q) begin
          adv_d = base_adv_q + 16'(gl_rdata - start_q);
        end else begin
          adv_d = base_adv_q;
        end
      end
      ST_OUT:   if (cmd_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      adv_q   <= '0;
    end else begin
      state_q <= state_d;
      adv_q   <= adv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_i;
      code_q     <= 7'(code_map - CHAR_SPACE);
      base_adv_q <= in_i.first_of_string ? 16'd0 : adv_q;
    end
    if (state_q == ST_START) start_q <= gl_rdata;
    if (state_q == ST_END) begin
      width_q <= (code_q != 7'(GlyphEntries - 1) && gl_rdata > start_q) ?
                 gl_rdata - start_q : 10'd0;
    end
  end

  assign cmd_valid_o = (state_q == ST_OUT);
  assign cmd_o.start = start_q;
  assign cmd_o.width = width_q;
  assign cmd_o.x     = 16'(item_q.origin_x) + base_adv_q;
  assign cmd_o.y     = item_q.origin_y;
  assign cmd_o.col   = to_rgb565(item_q.colour_rgb888);
endmodule

FILE: rtl/pgr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph row renderer back part
// Walk glyph rows and bitmap bytes, build masks, queue row results.
// ----------------------------------------------------------------------------
`include "proportional_glyph_row_renderer_top_defines.svh"
module pgr_back #(
  parameter int unsigned FontRows      = pgr_pkg::FontRowsDef,
  parameter int unsigned RowBytes      = pgr_pkg::RowBytesDef,
  parameter int unsigned MaxGlyphWidth = pgr_pkg::MaxGlyphWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  pgr_pkg::draw_cmd_t cmd_i,
  input  logic               bm_we_i,
  input  logic [10:0]        bm_waddr_i,
  input  logic [7:0]         bm_wdata_i,
  output logic               empty_o,
  input  logic               pop_i,
  output pgr_pkg::out_item_t out_o
);
  import pgr_pkg::*;

  localparam int unsigned Rows  = (FontRows < ResultLimit) ? FontRows : ResultLimit;
  localparam int unsigned Limit = (MaxGlyphWidth < MaskW) ? MaxGlyphWidth : MaskW;
  localparam int unsigned Bytes = (Limit + 14) / 8;

  // State codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]   state_q, state_d;
  draw_cmd_t    cmd_q;
  logic [4:0]   row_q;
  logic [3:0]   byte_q;
  logic         rd_pend_q;
  logic [3:0]   rd_byte_q;
  logic [39:0]  win_q;
  logic [10:0]  bm_raddr;
  logic [7:0]   bm_rdata;
  logic [31:0]  mask;
  logic         q_full;
  out_item_t    res_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         q_push, q_pop;

  assign bm_raddr = 11'({1'b0, cmd_q.start[9:3]} + 11'(byte_q) +
                        11'(32'(row_q) * RowBytes));

  pgr_ram #(.Width(8), .Depth(BitmapDepth)) u_bitmap (
    .clk_i, .we_i(bm_we_i), .waddr_i(bm_waddr_i), .wdata_i(bm_wdata_i),
    .raddr_i(bm_raddr), .rdata_o(bm_rdata)
  );

  always_comb begin
    logic [39:0] sh;
    sh = win_q << cmd_q.start[2:0];
    for (int p = 0; p < MaskW; p++) begin
      mask[p] = (p < Limit) && (10'(p) < cmd_q.width) && !sh[39 - p];
    end
  end

  assign q_full      = (cnt_q == 2'd2);
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign q_push      = (state_q == ST_PUSH) && !q_full;
  assign empty_o     = (cnt_q == 2'd0);
  assign q_pop       = pop_i && !empty_o;
  assign out_o       = res_q[rd_ptr_q];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_valid_i) state_d = ST_READ;
      ST_READ: if (rd_pend_q && rd_byte_q == 4'(Bytes - 1)) state_d = ST_PUSH;
      ST_PUSH: if (q_push) state_d = (row_q == 5'(Rows - 1)) ? ST_IDLE : ST_READ;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_pend_q <= 1'b0;
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == ST_READ) && byte_q < 4'(Bytes);
      if (q_push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cmd_q  <= cmd_i;
      row_q  <= '0;
      byte_q <= '0;
    end
    if (state_q == ST_READ && byte_q < 4'(Bytes)) byte_q <= byte_q + 4'd1;
    rd_byte_q <= byte_q;
    if (rd_pend_q) win_q[39 - 8*rd_byte_q -: 8] <= bm_rdata;
    if (q_push) begin
      res_q[wr_ptr_q].row_x         <= cmd_q.x;
      res_q[wr_ptr_q].row_y         <= cmd_q.y + 16'(row_q);
      res_q[wr_ptr_q].span_width    <= cmd_q.width;
      res_q[wr_ptr_q].pixel_mask    <= mask;
      res_q[wr_ptr_q].colour_rgb565 <= cmd_q.col;
      res_q[wr_ptr_q].width_clipped <= cmd_q.width > 10'(Limit);
      res_q[wr_ptr_q].last_row      <= row_q == 5'(Rows - 1);
      row_q  <= row_q + 5'd1;
      byte_q <= '0;
    end
  end

  `PGR_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "result queue count overflow")
  `PGR_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, q_full && q_push, "push into full queue")
  `PGR_ASSERT(a_row_range, clk_i, rst_ni, state_q == ST_IDLE || row_q < 5'(Rows),
              "row counter out of range")
endmodule
